/* rtl/ilm_pkg.sv */
// Shared constants, types and lattice index helpers for the Ising Metropolis engine.
package ilm_pkg;

    localparam int SIDE      = 32;
    localparam int COORD_W   = (SIDE > 1) ? $clog2(SIDE) : 1;
    localparam int ROWS      = SIDE * SIDE;
    localparam int ROW_W     = $clog2(ROWS);
    localparam int SITES     = SIDE * SIDE * SIDE;
    localparam int FIELD_W   = 5;
    localparam int RAND_W    = 16;
    localparam int THR_W     = 17;
    localparam int MAG_W     = 17;
    localparam int NB_W      = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_THR_4  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_THR_8  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_THR_12 = CFG_IDX_W'(2);

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_ATTEMPT = 1'b1;

    localparam logic signed [MAG_W-1:0] MAG_RESET = MAG_W'(SITES);
    localparam logic signed [MAG_W-1:0] MAG_STEP  = MAG_W'(2);

    typedef struct packed {
        logic [THR_W-1:0] thr_4;
        logic [THR_W-1:0] thr_8;
        logic [THR_W-1:0] thr_12;
    } thr_t;

    typedef struct packed {
        logic                    spin_now;
        logic                    flipped;
        logic signed [MAG_W-1:0] magnetization;
    } result_t;

    function automatic logic [COORD_W-1:0] coord_reduce(input logic [FIELD_W-1:0] v);
        return COORD_W'(v % SIDE);
    endfunction

    function automatic logic [COORD_W-1:0] wrap_up(input logic [COORD_W-1:0] c);
        return (c == COORD_W'(SIDE - 1)) ? '0 : COORD_W'(c + 1'b1);
    endfunction

    function automatic logic [COORD_W-1:0] wrap_down(input logic [COORD_W-1:0] c);
        return (c == '0) ? COORD_W'(SIDE - 1) : COORD_W'(c - 1'b1);
    endfunction

    function automatic logic [ROW_W-1:0] row_addr(input logic [COORD_W-1:0] x,
                                                  input logic [COORD_W-1:0] y);
        return ROW_W'(x * SIDE + y);
    endfunction

endpackage

/* rtl/ilm_ram.sv */
// Generic RAM with one write port and two registered read ports.
module ilm_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr0,
    output logic [DATA_W-1:0] rdata0,
    input  logic [ADDR_W-1:0] raddr1,
    output logic [DATA_W-1:0] rdata1
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

/* rtl/ilm_cfg.sv */
// Acceptance threshold registers written through the configuration channel.
module ilm_cfg
    import ilm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [THR_W-1:0]     cfg_data,
    output thr_t                 thr
);

    thr_t thr_reg;

    assign cfg_ready = 1'b1;
    assign thr       = thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_THR_4:  thr_reg.thr_4  <= cfg_data;
                CFG_THR_8:  thr_reg.thr_8  <= cfg_data;
                CFG_THR_12: thr_reg.thr_12 <= cfg_data;
                default:    thr_reg        <= thr_reg;
            endcase
        end
    end

endmodule

/* rtl/ilm_ctrl.sv */
// Sequencer: clears the lattice, gathers neighbor rows, decides the flip and writes back.
module ilm_ctrl
    import ilm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               in_cmd,
    input  logic [FIELD_W-1:0] in_x,
    input  logic [FIELD_W-1:0] in_y,
    input  logic [FIELD_W-1:0] in_z,
    input  logic               in_spin,
    input  logic [RAND_W-1:0]  in_rand,
    input  thr_t               thr,
    input  logic               out_free,
    output logic               res_push,
    output result_t            res
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD1,
        ST_RD2,
        ST_EVAL
    } state_t;

    state_t                  state_reg, state_next;
    logic [ROW_W-1:0]        clr_cnt_reg;
    logic signed [MAG_W-1:0] mag_reg, mag_next;

    logic                    cmd_reg;
    logic                    spin_reg;
    logic [RAND_W-1:0]       rand_reg;
    logic [COORD_W-1:0]      x_reg, y_reg, z_reg;
    logic [SIDE-1:0]         word_reg;
    logic                    xp_reg, xm_reg, yp_reg;

    logic [COORD_W-1:0]      cx, cy, cz;
    logic                    in_accept;
    logic                    ram_we;
    logic [ROW_W-1:0]        ram_waddr;
    logic [SIDE-1:0]         ram_wdata;
    logic [ROW_W-1:0]        raddr0, raddr1;
    logic [SIDE-1:0]         rdata0, rdata1;

    logic                    cbit;
    logic                    ym_bit;
    logic [5:0]              diff;
    logic [NB_W-1:0]         nb_diff;
    logic [THR_W-1:0]        rand_ext;
    logic                    accept;
    logic                    new_bit;
    logic [SIDE-1:0]         word_new;

    ilm_ram #(
        .DATA_W (SIDE),
        .DEPTH  (ROWS),
        .ADDR_W (ROW_W)
    ) u_lattice (
        .clk    (clk),
        .we     (ram_we),
        .waddr  (ram_waddr),
        .wdata  (ram_wdata),
        .raddr0 (raddr0),
        .rdata0 (rdata0),
        .raddr1 (raddr1),
        .rdata1 (rdata1)
    );

    assign cx        = coord_reduce(in_x);
    assign cy        = coord_reduce(in_y);
    assign cz        = coord_reduce(in_z);
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        case (state_reg)
            ST_IDLE:
            begin
                raddr0 = row_addr(cx, cy);
                raddr1 = row_addr(wrap_up(cx), cy);
            end
            ST_RD1:
            begin
                raddr0 = row_addr(wrap_down(x_reg), y_reg);
                raddr1 = row_addr(x_reg, wrap_up(y_reg));
            end
            default:
            begin
                raddr0 = row_addr(x_reg, wrap_down(y_reg));
                raddr1 = row_addr(x_reg, wrap_down(y_reg));
            end
        endcase
    end

    assign cbit     = word_reg[z_reg];
    assign ym_bit   = rdata0[z_reg];
    assign diff     = {word_reg[wrap_up(z_reg)], word_reg[wrap_down(z_reg)],
                       xp_reg, xm_reg, yp_reg, ym_bit} ^ {6{cbit}};
    assign nb_diff  = NB_W'($countones(diff));
    assign rand_ext = {{(THR_W - RAND_W){1'b0}}, rand_reg};

    always_comb
    begin
        case (nb_diff) inside
            3'd0:         accept = rand_ext < thr.thr_12;
            3'd1:         accept = rand_ext < thr.thr_8;
            3'd2:         accept = rand_ext < thr.thr_4;
            [3'd3:3'd6]:  accept = 1'b1;
            default:      accept = 1'b1;
        endcase
    end

    always_comb
    begin
        new_bit           = (cmd_reg == CMD_LOAD) ? spin_reg : (cbit ^ accept);
        word_new          = word_reg;
        word_new[z_reg]   = new_bit;
        res_push          = (state_reg == ST_EVAL) && out_free;
        res.spin_now      = new_bit;
        res.flipped       = (cmd_reg == CMD_ATTEMPT) && accept;
        if (new_bit == cbit)
        begin
            mag_next = mag_reg;
        end
        else if (new_bit)
        begin
            mag_next = mag_reg - MAG_STEP;
        end
        else
        begin
            mag_next = mag_reg + MAG_STEP;
        end
        res.magnetization = mag_next;
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = row_addr(x_reg, y_reg);
        ram_wdata = word_new;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
            end
            ST_EVAL:
            begin
                ram_we = out_free;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == ROW_W'(ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_RD1;
                end
            end
            ST_RD1:  state_next = ST_RD2;
            ST_RD2:  state_next = ST_EVAL;
            ST_EVAL:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            mag_reg     <= MAG_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= ROW_W'(clr_cnt_reg + 1'b1);
            end
            if (res_push)
            begin
                mag_reg <= mag_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg  <= in_cmd;
            spin_reg <= in_spin;
            rand_reg <= in_rand;
            x_reg    <= cx;
            y_reg    <= cy;
            z_reg    <= cz;
        end
        if (state_reg == ST_RD1)
        begin
            word_reg <= rdata0;
            xp_reg   <= rdata1[z_reg];
        end
        if (state_reg == ST_RD2)
        begin
            xm_reg <= rdata0[z_reg];
            yp_reg <= rdata1[z_reg];
        end
    end

    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_EVAL || state_reg == ST_CLEAR))
        else $error("lattice written outside clear or evaluate");

    a_mag_step: assert property (@(posedge clk) disable iff (!rst_n)
        (mag_reg != $past(mag_reg)) |->
            ((MAG_W'(mag_reg - $past(mag_reg)) == MAG_STEP) ||
             (MAG_W'($past(mag_reg) - mag_reg) == MAG_STEP)))
        else $error("magnetization moved by other than two");

    a_mag_when_push: assert property (@(posedge clk) disable iff (!rst_n)
        (mag_reg != $past(mag_reg)) |-> $past(res_push))
        else $error("magnetization changed without a result");

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> out_free)
        else $error("result pushed into a full output stage");

    a_load_no_flip: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && (cmd_reg == CMD_LOAD)) |-> !res.flipped)
        else $error("load request reported a flip");

endmodule

/* rtl/ising_metropolis_3d_lattice_top.sv */
// Top level of the Ising Metropolis engine: stream ports, threshold registers, output stage.
//
//   channel  direction  handshake            payload
//   s_*      in         s_tvalid/s_tready    s_tdata 32b, s_tuser 1b (command)
//   m_*      out        m_tvalid/m_tready    m_tdata 24b
//   cfg_*    in         cfg_valid/cfg_ready  cfg_index 2b, cfg_data 17b
//
// The two-read-port lattice memory yields the site row and four neighbor rows over the
// states IDLE, RD1 and RD2; then the EVAL state evaluates and writes back.
// After reset a clearing pass writes every one of the SIDE*SIDE (1024) rows; s_tready
// stays low meanwhile, configuration writes are taken as usual.
// While the output register is full and m_tready low, evaluation holds; the next
// request is accepted as soon as the result moves into the output register.
module ising_metropolis_3d_lattice_top
    import ilm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // site_x, site_y, site_z, spin_value, random_value
    input  logic                 s_tuser,   // command
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,   // spin_now, flipped, magnetization, zero fill
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [THR_W-1:0]     cfg_data
);

    thr_t    thr;
    logic    out_free;
    logic    res_push;
    result_t res;
    logic    out_valid_reg;
    result_t out_reg;

    ilm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .thr       (thr)
    );

    ilm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_cmd   (s_tuser),
        .in_x     (s_tdata[4:0]),
        .in_y     (s_tdata[9:5]),
        .in_z     (s_tdata[14:10]),
        .in_spin  (s_tdata[15]),
        .in_rand  (s_tdata[31:16]),
        .thr      (thr),
        .out_free (out_free),
        .res_push (res_push),
        .res      (res)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_reg.magnetization, out_reg.flipped, out_reg.spin_now};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            out_reg <= res;
        end
    end

endmodule
